// ===== rtl/websocket_frame_receiver_core_macros.svh =====
// Assertion macros used by the frame receiver core.
`ifndef WEBSOCKET_FRAME_RECEIVER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define WSFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define WSFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wsfr_pkg.sv =====
// Package with the types and constants of the frame receiver.
`timescale 1ns / 1ps

package wsfr_pkg;

    localparam int unsigned LEN_W = 63;

    // Item kinds
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_BYTE   = 1'b1;

    // Opcodes
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // Result events
    localparam logic [3:0] EV_ACCEPT     = 4'd0;
    localparam logic [3:0] EV_MSG        = 4'd1;
    localparam logic [3:0] EV_PONG       = 4'd2;
    localparam logic [3:0] EV_CLOSE      = 4'd3;
    localparam logic [3:0] EV_PROTO      = 4'd4;
    localparam logic [3:0] EV_BIG        = 4'd5;
    localparam logic [3:0] EV_EMPTY_MSG  = 4'd6;
    localparam logic [3:0] EV_EMPTY_PONG = 4'd7;
    localparam logic [3:0] EV_IGNORED    = 4'd8;

    localparam logic [15:0] CODE_PROTO  = 16'd1002;
    localparam logic [15:0] CODE_NORMAL = 16'd1000;

    localparam logic [LEN_W-1:0] CTRL_MAX          = 63'd125;
    localparam logic [31:0]      MAX_PAYLOAD_RESET = 32'd512;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DRAIN   = 2'd2
    } phase_t;

    typedef struct packed {
        logic             cmd;
        logic             fin;
        logic [2:0]       rsv_bits;
        logic [3:0]       frame_op;
        logic             mask_flag;
        logic [31:0]      masking_key;
        logic [LEN_W-1:0] frame_len;
        logic [7:0]       data_byte;
    } item_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  out_byte;
        logic        last;
        logic [3:0]  message_type;
        logic [15:0] close_code;
        logic        connection_open;
    } result_t;

endpackage

// ===== rtl/websocket_frame_receiver_core.sv =====
// Top level of the frame receiver: header checks, unmasking and reply events.
// An item is registered in the input register, then in the result register.
// Throughput: one item per cycle while result_ready allows; the input register
// and the result register form a two-stage pipeline, and all per-item work
// (63-bit length compares and one decrement) sits between them.
// Reset: asynchronous, active low; link open, awaiting header, max_payload = 512.
`timescale 1ns / 1ps
`include "websocket_frame_receiver_core_macros.svh"

module websocket_frame_receiver_core (
    input  logic                clk,
    input  logic                rst_n,
    // Item channel
    input  logic                item_valid,
    output logic                item_ready,
    input  wsfr_pkg::item_t     item,
    // Result channel
    output logic                result_valid,
    input  logic                result_ready,
    output wsfr_pkg::result_t   result,
    // Configuration write channel (max_payload)
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    wsfr_pkg::item_t   s1_reg;
    logic              result_valid_reg;
    wsfr_pkg::result_t result_reg;

    logic s2_ready;
    logic s1_fire;
    logic item_fire;

    // The result register takes a new value when empty or being drained.
    assign s2_ready   = !result_valid_reg || result_ready;
    assign s1_fire    = s1_valid_reg && s2_ready;
    assign item_ready = !s1_valid_reg || s2_ready;
    assign item_fire  = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Receiver state
    // ------------------------------------------------------------------
    logic [31:0]                  max_payload_reg;
    logic                         link_open_reg,  link_open_next;
    wsfr_pkg::phase_t             phase_reg,      phase_next;
    logic [wsfr_pkg::LEN_W-1:0]   rem_reg,        rem_next;
    logic [3:0]                   cur_op_reg,     cur_op_next;
    logic [31:0]                  cur_mask_reg,   cur_mask_next;
    logic [1:0]                   mask_pos_reg,   mask_pos_next;
    logic [15:0]                  peer_code_reg,  peer_code_next;
    logic [1:0]                   code_seen_reg,  code_seen_next;
    wsfr_pkg::result_t            res_next;

    // Per-item working values
    logic                         hdr_bad;
    logic                         is_ctrl;
    logic                         too_big;
    logic [wsfr_pkg::LEN_W-1:0]   rem_dec;
    logic                         byte_fin;
    logic [7:0]                   key_byte;
    logic [7:0]                   plain_byte;

    assign is_ctrl = (s1_reg.frame_op == wsfr_pkg::OP_CLOSE)
                  || (s1_reg.frame_op == wsfr_pkg::OP_PING)
                  || (s1_reg.frame_op == wsfr_pkg::OP_PONG);

    // Header checks in protocol order collapse to one error flag.
    assign hdr_bad = (s1_reg.rsv_bits != 3'd0)
                  || !s1_reg.fin
                  || (s1_reg.frame_op == wsfr_pkg::OP_CONT)
                  || !s1_reg.mask_flag
                  || (is_ctrl && (s1_reg.frame_len > wsfr_pkg::CTRL_MAX));

    assign too_big  = s1_reg.frame_len > {31'd0, max_payload_reg};
    assign rem_dec  = rem_reg - 63'd1;
    // Last byte of the frame when exactly one is left.
    assign byte_fin = (rem_reg == 63'd1);

    // Pick the key byte for this position, first wire byte from the top.
    always_comb
    begin
        unique case (mask_pos_reg)
            2'd0:    key_byte = cur_mask_reg[31:24];
            2'd1:    key_byte = cur_mask_reg[23:16];
            2'd2:    key_byte = cur_mask_reg[15:8];
            default: key_byte = cur_mask_reg[7:0];
        endcase
    end

    assign plain_byte = s1_reg.data_byte ^ key_byte;

    // ------------------------------------------------------------------
    // Per-item decision
    // ------------------------------------------------------------------
    always_comb
    begin
        link_open_next = link_open_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        cur_op_next    = cur_op_reg;
        cur_mask_next  = cur_mask_reg;
        mask_pos_next  = mask_pos_reg;
        peer_code_next = peer_code_reg;
        code_seen_next = code_seen_reg;

        res_next              = '0;
        res_next.event_res    = wsfr_pkg::EV_IGNORED;

        if (!link_open_reg)
        begin
            // Closed link: ignore everything, keep state.
        end
        else if (s1_reg.cmd == wsfr_pkg::CMD_HEADER)
        begin
            // Header transfer
            if (phase_reg != wsfr_pkg::PH_HEADER)
            begin
                // Out of turn: ignore it.
            end
            else if (hdr_bad)
            begin
                link_open_next        = 1'b0;
                phase_next            = wsfr_pkg::PH_HEADER;
                rem_next              = '0;
                res_next.event_res    = wsfr_pkg::EV_PROTO;
                res_next.message_type = s1_reg.frame_op;
                res_next.close_code   = wsfr_pkg::CODE_PROTO;
            end
            else
            begin
                cur_op_next           = s1_reg.frame_op;
                res_next.message_type = s1_reg.frame_op;
                if (too_big)
                begin
                    // Drain the oversized payload.
                    phase_next         = wsfr_pkg::PH_DRAIN;
                    rem_next           = s1_reg.frame_len;
                    res_next.event_res = wsfr_pkg::EV_ACCEPT;
                end
                else if (s1_reg.frame_len == '0)
                begin
                    unique case (s1_reg.frame_op)
                        wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BINARY:
                            res_next.event_res = wsfr_pkg::EV_EMPTY_MSG;
                        wsfr_pkg::OP_PING:
                            res_next.event_res = wsfr_pkg::EV_EMPTY_PONG;
                        wsfr_pkg::OP_PONG:
                            res_next.event_res = wsfr_pkg::EV_IGNORED;
                        wsfr_pkg::OP_CLOSE:
                        begin
                            link_open_next      = 1'b0;
                            res_next.event_res  = wsfr_pkg::EV_CLOSE;
                            res_next.close_code = wsfr_pkg::CODE_NORMAL;
                        end
                        default:
                        begin
                            link_open_next      = 1'b0;
                            phase_next          = wsfr_pkg::PH_HEADER;
                            rem_next            = '0;
                            res_next.event_res  = wsfr_pkg::EV_PROTO;
                            res_next.close_code = wsfr_pkg::CODE_PROTO;
                        end
                    endcase
                end
                else
                begin
                    // Start a payload: latch key, reset close code capture.
                    phase_next         = wsfr_pkg::PH_PAYLOAD;
                    rem_next           = s1_reg.frame_len;
                    cur_mask_next      = s1_reg.masking_key;
                    mask_pos_next      = 2'd0;
                    peer_code_next     = wsfr_pkg::CODE_NORMAL;
                    code_seen_next     = 2'd0;
                    res_next.event_res = wsfr_pkg::EV_ACCEPT;
                end
            end
        end
        else if ((phase_reg == wsfr_pkg::PH_PAYLOAD) && (rem_reg != '0))
        begin
            // Payload byte: unmask and route by opcode.
            mask_pos_next         = mask_pos_reg + 2'd1;
            rem_next              = rem_dec;
            if (byte_fin)
            begin
                phase_next = wsfr_pkg::PH_HEADER;
            end
            res_next.message_type = cur_op_reg;
            res_next.event_res    = wsfr_pkg::EV_ACCEPT;

            unique case (cur_op_reg)
                wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BINARY:
                begin
                    res_next.event_res = wsfr_pkg::EV_MSG;
                    res_next.out_byte  = plain_byte;
                    res_next.last      = byte_fin;
                end
                wsfr_pkg::OP_PING:
                begin
                    res_next.event_res = wsfr_pkg::EV_PONG;
                    res_next.out_byte  = plain_byte;
                    res_next.last      = byte_fin;
                end
                wsfr_pkg::OP_PONG:
                begin
                    if (byte_fin)
                    begin
                        res_next.event_res = wsfr_pkg::EV_IGNORED;
                    end
                end
                wsfr_pkg::OP_CLOSE:
                begin
                    // Capture the peer's status code, high byte first.
                    if (code_seen_reg == 2'd0)
                    begin
                        peer_code_next = {plain_byte, 8'd0};
                        code_seen_next = 2'd1;
                    end
                    else if (code_seen_reg == 2'd1)
                    begin
                        peer_code_next = {peer_code_reg[15:8], plain_byte};
                        code_seen_next = 2'd2;
                    end
                    if (byte_fin)
                    begin
                        link_open_next      = 1'b0;
                        res_next.event_res  = wsfr_pkg::EV_CLOSE;
                        res_next.close_code = (code_seen_next >= 2'd2)
                                            ? peer_code_next
                                            : wsfr_pkg::CODE_NORMAL;
                    end
                end
                default:
                begin
                    // Unknown opcode: consume, then fail at the end.
                    if (byte_fin)
                    begin
                        link_open_next      = 1'b0;
                        phase_next          = wsfr_pkg::PH_HEADER;
                        rem_next            = '0;
                        res_next.event_res  = wsfr_pkg::EV_PROTO;
                        res_next.close_code = wsfr_pkg::CODE_PROTO;
                    end
                end
            endcase
        end
        else if ((phase_reg == wsfr_pkg::PH_DRAIN) && (rem_reg != '0))
        begin
            // Drop the byte; report too large on the final one.
            rem_next              = rem_dec;
            res_next.message_type = cur_op_reg;
            if (byte_fin)
            begin
                phase_next         = wsfr_pkg::PH_HEADER;
                res_next.event_res = wsfr_pkg::EV_BIG;
            end
            else
            begin
                res_next.event_res = wsfr_pkg::EV_ACCEPT;
            end
        end
        else
        begin
            // Stray byte: ignore it and go back to waiting for a header.
            phase_next = wsfr_pkg::PH_HEADER;
        end

        res_next.connection_open = link_open_next;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // Input stage: hold the item until the result register can take it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_reg <= item;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_reg <= res_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= wsfr_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_payload_reg <= cfg_data;
        end
    end

    // Advance the receiver state once per item that enters the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_open_reg <= 1'b1;
            phase_reg     <= wsfr_pkg::PH_HEADER;
            rem_reg       <= '0;
            cur_op_reg    <= wsfr_pkg::OP_CONT;
            cur_mask_reg  <= 32'd0;
            mask_pos_reg  <= 2'd0;
            peer_code_reg <= wsfr_pkg::CODE_NORMAL;
            code_seen_reg <= 2'd0;
        end
        else if (s1_fire)
        begin
            link_open_reg <= link_open_next;
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            cur_op_reg    <= cur_op_next;
            cur_mask_reg  <= cur_mask_next;
            mask_pos_reg  <= mask_pos_next;
            peer_code_reg <= peer_code_next;
            code_seen_reg <= code_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WSFR_ASSERT_SAME(a_phase_has_bytes, phase_reg != wsfr_pkg::PH_HEADER, rem_reg != '0, "frame phase with no bytes left")
    `WSFR_ASSERT_NEXT(a_closed_ignores, s1_fire && !link_open_reg, result_reg.event_res == wsfr_pkg::EV_IGNORED, "closed link produced an event")
    `WSFR_ASSERT_SAME(a_close_reason, $fell(link_open_reg), result_reg.event_res == wsfr_pkg::EV_CLOSE || result_reg.event_res == wsfr_pkg::EV_PROTO, "link closed without close or error")

endmodule
